// ===== design/tkr_pkg.sv =====
`default_nettype none
package tkr_pkg;

    localparam int ID_W       = 22;
    localparam int TICK_W     = 32;
    localparam int TOTAL_W    = 33;
    localparam int RANK_W     = 7;
    localparam int TOPCNT_W   = 7;
    localparam int PDATA_W    = 32;
    localparam int PADDR_W    = 3;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_TOP_DEPTH   = 64;

    localparam logic [TOPCNT_W-1:0] TOP_COUNT_RESET = 7'd10;

    // Word index of each configuration register (paddr[2]).
    localparam logic REG_TOP_COUNT = 1'b0;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TOTAL_W-1:0] total;
    } entry_t;

    typedef struct packed {
        logic [TOPCNT_W-1:0] top_count;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

// ===== design/top_k_record_ranker_core.sv =====
// Top-k record ranker.
// Records enter on the command channel: an item is taken at a rising edge with
// start high and busy low. Each record's key is user_ticks + system_ticks, and
// the best TOP_DEPTH records of the current set are kept in a synchronous RAM,
// sorted descending, with earlier arrivals ahead on equal keys.
// Insertion walks up from the bottom of the held list, one RAM entry per cycle,
// moving each smaller entry down by one slot. Records beyond MAX_ENTRIES in a
// set are dropped.
// On the record with set_end, after its insertion, the block reads the first
// min(top_count, held) entries one per cycle; each result shows on rank,
// ranked_id, total_ticks and run_end for one cycle with result_strobe high,
// in the cycle after its entry is read. The receiver cannot stall.
// busy stays high until the read phase ends, in the cycle after the last read.
// top_count is set through the APB port (word 0, reset 10). Reset empties the
// set; the RAM needs no clearing since only written entries are ever read.
`default_nettype none
module top_k_record_ranker_core #(
    parameter int MAX_ENTRIES = tkr_pkg::DEF_MAX_ENTRIES,
    parameter int TOP_DEPTH   = tkr_pkg::DEF_TOP_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [tkr_pkg::ID_W-1:0]     proc_id,
    input  wire logic [tkr_pkg::TICK_W-1:0]   user_ticks,
    input  wire logic [tkr_pkg::TICK_W-1:0]   system_ticks,
    input  wire logic                         set_end,
    output logic                              result_strobe,
    output logic      [tkr_pkg::RANK_W-1:0]   rank,
    output logic      [tkr_pkg::ID_W-1:0]     ranked_id,
    output logic      [tkr_pkg::TOTAL_W-1:0]  total_ticks,
    output logic                              run_end,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tkr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tkr_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tkr_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CW     = $clog2(TOP_DEPTH + 1);
    localparam int AW     = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
    localparam int CMPW   = CW + tkr_pkg::TOPCNT_W;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
    localparam logic [CW-1:0]    DEPTH_C = CW'(TOP_DEPTH);

    tkr_pkg::cfg_t cfg;

    tkr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tkr_pkg::entry_t mem [TOP_DEPTH];

    tkr_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]    held_reg, held_next;
    logic [CW-1:0]    idx_reg, idx_next;
    tkr_pkg::entry_t  new_reg, new_next;
    logic             last_reg, last_next;
    tkr_pkg::entry_t  rd_data_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [tkr_pkg::RANK_W-1:0] out_rank_reg, out_rank_next;
    logic                      out_end_reg, out_end_next;

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    tkr_pkg::entry_t wr_data;

    logic [CW-1:0]   emit_cnt;
    logic [CW-1:0]   idx_inc;
    logic [CW-1:0]   idx_dec;
    logic [CW-1:0]   idx_dec2;
    logic [CW-1:0]   held_dec;

    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);
    assign idx_dec2 = idx_reg - CW'(2);
    assign held_dec = held_reg - CW'(1);

    // Emit count is min(top_count, held); held never exceeds TOP_DEPTH.
    always_comb
    begin
        if (CMPW'(cfg.top_count) >= CMPW'(held_reg))
        begin
            emit_cnt = held_reg;
        end
        else
        begin
            emit_cnt = cfg.top_count[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tkr_pkg::ST_IDLE;
            cnt_reg       <= '0;
            held_reg      <= '0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            held_reg      <= held_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg      <= new_next;
        out_rank_reg <= out_rank_next;
        out_end_reg  <= out_end_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        held_next      = held_reg;
        idx_next       = idx_reg;
        new_next       = new_reg;
        last_next      = last_reg;
        out_valid_next = 1'b0;
        out_rank_next  = out_rank_reg;
        out_end_next   = out_end_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_dec[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = idx_reg[AW-1:0];
        wr_data        = new_reg;

        case (state_reg)
            tkr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    new_next.id    = proc_id;
                    new_next.total = tkr_pkg::TOTAL_W'(user_ticks)
                                     + tkr_pkg::TOTAL_W'(system_ticks);
                    last_next      = set_end;
                    if (cnt_reg < MAX_CNT)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (held_reg != DEPTH_C)
                        begin
                            held_next = held_reg + CW'(1);
                        end
                        idx_next = held_reg;
                        if (held_reg == '0)
                        begin
                            state_next = tkr_pkg::ST_PLACE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = held_dec[AW-1:0];
                            state_next = tkr_pkg::ST_SHIFT;
                        end
                    end
                    else if (set_end)
                    begin
                        idx_next   = '0;
                        state_next = tkr_pkg::ST_EMIT;
                    end
                end
            end

            // rd_data_reg holds entry idx-1; move it down while it ranks below
            // the new record. A slot at TOP_DEPTH is past the end and is dropped.
            tkr_pkg::ST_SHIFT:
            begin
                if (rd_data_reg.total < new_reg.total)
                begin
                    wr_en    = (idx_reg != DEPTH_C);
                    wr_data  = rd_data_reg;
                    idx_next = idx_dec;
                    if (idx_reg == CW'(1))
                    begin
                        state_next = tkr_pkg::ST_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_dec2[AW-1:0];
                    end
                end
                else
                begin
                    wr_en = (idx_reg != DEPTH_C);
                    if (last_reg)
                    begin
                        idx_next   = '0;
                        state_next = tkr_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = tkr_pkg::ST_IDLE;
                    end
                end
            end

            tkr_pkg::ST_PLACE:
            begin
                wr_en = 1'b1;
                if (last_reg)
                begin
                    idx_next   = '0;
                    state_next = tkr_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = tkr_pkg::ST_IDLE;
                end
            end

            tkr_pkg::ST_EMIT:
            begin
                if (idx_reg == emit_cnt)
                begin
                    cnt_next   = '0;
                    held_next  = '0;
                    state_next = tkr_pkg::ST_IDLE;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = idx_reg[AW-1:0];
                    out_valid_next = 1'b1;
                    out_rank_next  = tkr_pkg::RANK_W'(idx_inc);
                    out_end_next   = (idx_inc == emit_cnt);
                    idx_next       = idx_inc;
                end
            end

            default:
            begin
                state_next = tkr_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != tkr_pkg::ST_IDLE);
    assign result_strobe = out_valid_reg;
    assign rank          = out_rank_reg;
    assign ranked_id     = rd_data_reg.id;
    assign total_ticks   = rd_data_reg.total;
    assign run_end       = out_end_reg;

endmodule
`default_nettype wire

// ===== design/tkr_cfg_regs.sv =====
`default_nettype none
module tkr_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tkr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tkr_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tkr_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output tkr_pkg::cfg_t                     cfg
);

    logic [tkr_pkg::TOPCNT_W-1:0] top_count_reg;
    logic                         wr_top_count;

    assign pready       = 1'b1;
    assign wr_top_count = psel && penable && pwrite
                          && (paddr[2] == tkr_pkg::REG_TOP_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_count_reg <= tkr_pkg::TOP_COUNT_RESET;
        end
        else if (wr_top_count)
        begin
            top_count_reg <= pwdata[tkr_pkg::TOPCNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == tkr_pkg::REG_TOP_COUNT)
        begin
            prdata = tkr_pkg::PDATA_W'(top_count_reg);
        end
    end

    assign cfg.top_count = top_count_reg;

endmodule
`default_nettype wire

// ===== tb/top_k_record_ranker_core_tb.sv =====
module top_k_record_ranker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tkr_pkg::*;

    localparam int MAX_ENTRIES  = DEF_MAX_ENTRIES;
    localparam int TOP_DEPTH    = DEF_TOP_DEPTH;
    localparam int SETTLE       = TOP_DEPTH + 16;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 14;

    typedef struct {
        logic [RANK_W-1:0]  rank;
        logic [ID_W-1:0]    id;
        logic [TOTAL_W-1:0] total;
        logic               run_end;
    } rank_result_t;

    // Keeps its own copy of the ranked list and predicts each emitted run.
    class ranking_tracker;
        entry_t              held [TOP_DEPTH];
        int                  set_count;
        logic [TOPCNT_W-1:0] top_count;
        rank_result_t        expected_ranks [$];
        int unsigned         errors;
        int unsigned         checked;
        int unsigned         sets_closed;

        function new();
            set_count   = 0;
            top_count   = TOP_COUNT_RESET;
            errors      = 0;
            checked     = 0;
            sets_closed = 0;
        endfunction

        function void set_top_count(logic [PDATA_W-1:0] word);
            top_count = word[TOPCNT_W-1:0];
        endfunction

        function int pending();
            return expected_ranks.size();
        endfunction

        function void note_record(logic [ID_W-1:0] id, logic [TICK_W-1:0] user,
                                  logic [TICK_W-1:0] sys, logic last);
            logic [TOTAL_W-1:0] total;
            int                 held_n;
            int                 pos;
            int                 i;
            int                 emit;
            rank_result_t       r;
            total  = {1'b0, user} + {1'b0, sys};
            held_n = (set_count < TOP_DEPTH) ? set_count : TOP_DEPTH;
            if (set_count < MAX_ENTRIES)
            begin
                // Strict compare: an equal total stays behind the earlier record.
                pos = 0;
                while (pos < held_n && held[pos].total >= total)
                    pos++;
                if (pos < TOP_DEPTH)
                begin
                    i = (held_n < TOP_DEPTH) ? held_n : TOP_DEPTH - 1;
                    while (i > pos)
                    begin
                        held[i] = held[i-1];
                        i--;
                    end
                    held[pos].id    = id;
                    held[pos].total = total;
                end
                set_count++;
            end
            if (last)
            begin
                held_n = (set_count < TOP_DEPTH) ? set_count : TOP_DEPTH;
                emit   = (top_count < TOP_DEPTH) ? int'(top_count) : TOP_DEPTH;
                if (emit > held_n)
                    emit = held_n;
                for (i = 0; i < emit; i++)
                begin
                    r.rank    = RANK_W'(i + 1);
                    r.id      = held[i].id;
                    r.total   = held[i].total;
                    r.run_end = (i + 1 == emit);
                    expected_ranks.push_back(r);
                end
                set_count = 0;
                sets_closed++;
            end
        endfunction

        function void check_rank(logic [RANK_W-1:0] rank, logic [ID_W-1:0] id,
                                 logic [TOTAL_W-1:0] total, logic run_end);
            rank_result_t e;
            if (expected_ranks.size() == 0)
            begin
                $error("unexpected ranked result: rank %0d id %0h total %0h", rank, id, total);
                errors++;
                return;
            end
            e = expected_ranks.pop_front();
            checked++;
            if (rank !== e.rank)
            begin
                $error("rank: expected %0d, actual %0d", e.rank, rank);
                errors++;
            end
            if (id !== e.id)
            begin
                $error("ranked_id: expected %0h, actual %0h", e.id, id);
                errors++;
            end
            if (total !== e.total)
            begin
                $error("total_ticks: expected %0h, actual %0h", e.total, total);
                errors++;
            end
            if (run_end !== e.run_end)
            begin
                $error("run_end: expected %0d, actual %0d", e.run_end, run_end);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [ID_W-1:0]     proc_id = '0;
    logic [TICK_W-1:0]   user_ticks = '0;
    logic [TICK_W-1:0]   system_ticks = '0;
    logic                set_end = 1'b0;
    logic                result_strobe;
    logic [RANK_W-1:0]   rank;
    logic [ID_W-1:0]     ranked_id;
    logic [TOTAL_W-1:0]  total_ticks;
    logic                run_end;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    ranking_tracker tracker = new();
    int unsigned    records_sent = 0;
    int unsigned    settings_used = 0;

    top_k_record_ranker_core #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .TOP_DEPTH(TOP_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .proc_id(proc_id),
        .user_ticks(user_ticks),
        .system_ticks(system_ticks),
        .set_end(set_end),
        .result_strobe(result_strobe),
        .rank(rank),
        .ranked_id(ranked_id),
        .total_ticks(total_ticks),
        .run_end(run_end),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            tracker.check_rank(rank, ranked_id, total_ticks, run_end);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("top_k_record_ranker_core verification failed");
        $finish;
    end

    // Holds start high until the block takes the record; gap cycles of idle come first.
    task automatic send_record(input logic [ID_W-1:0] id, input logic [TICK_W-1:0] user,
                               input logic [TICK_W-1:0] sys, input logic last,
                               input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        proc_id      <= id;
        user_ticks   <= user;
        system_ticks <= sys;
        set_end      <= last;
        do
            @(posedge clk);
        while (busy);
        tracker.note_record(id, user, sys, last);
        records_sent++;
    endtask

    // Stops sending and lets every expected result come out, then lets any
    // insertion that produces no result finish.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_top_count(input logic [TOPCNT_W-1:0] value);
        logic [PDATA_W-1:0] word;
        // Upper data bits carry noise; only the low bits belong to the register.
        word = ($urandom << TOPCNT_W) | PDATA_W'(value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TOP_COUNT, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.set_top_count(word);
        settings_used++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [TICK_W-1:0] rand_ticks();
        case ($urandom_range(0, 3))
            0: return TICK_W'($urandom_range(0, 3));
            1: return {TICK_W{1'b1}} - TICK_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_set(input int count, input bit burst);
        int k;
        for (k = 0; k < count; k++)
            send_record(ID_W'($urandom), rand_ticks(), rand_ticks(), k == count - 1,
                        burst ? 0 : $urandom_range(0, 13));
    endtask

    initial
    begin
        int                  k;
        int                  phase_count;
        int                  set_size;
        logic [TOPCNT_W-1:0] phase_setting [5];
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset value of top_count, extreme fields and equal totals.
        send_record('0, '0, '0, 1'b0, 0);
        send_record({ID_W{1'b1}}, {TICK_W{1'b1}}, {TICK_W{1'b1}}, 1'b0, 1);
        send_record(22'd1, 32'd5, 32'd5, 1'b0, 0);
        send_record(22'd2, 32'd10, 32'd0, 1'b0, 3);
        send_record(22'd3, 32'd0, 32'd10, 1'b0, 0);
        send_record(22'h2AAAAA, 32'hAAAAAAAA, 32'h55555555, 1'b0, 0);
        send_record(22'h155555, 32'h55555555, 32'hAAAAAAAA, 1'b1, 2);
        send_record(22'h00ABCD, 32'd7, 32'd9, 1'b1, 0);

        // A zero top_count closes the set without any result.
        drain_results();
        write_top_count(7'd0);
        send_random_set(3, 1'b1);

        // Values above the store depth are clipped to it.
        drain_results();
        write_top_count(7'd127);
        send_random_set(5, 1'b0);

        drain_results();
        write_top_count(7'd3);
        send_random_set(6, 1'b1);

        // A set larger than the store: the early records fill it, and the later
        // ones carry the largest total and push the lowest entries out.
        drain_results();
        write_top_count(7'd64);
        for (k = 0; k < TOP_DEPTH; k++)
            send_record(ID_W'($urandom), rand_ticks() >> 1, rand_ticks() >> 1, 1'b0,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 13) : 0);
        for (k = 0; k < 6; k++)
            send_record(ID_W'($urandom), {TICK_W{1'b1}}, {TICK_W{1'b1}}, k == 5, 0);

        phase_setting[0] = 7'd64;
        phase_setting[1] = 7'd1;
        phase_setting[2] = 7'd65;
        phase_setting[3] = TOPCNT_W'($urandom_range(2, 63));
        phase_setting[4] = TOP_COUNT_RESET;
        for (k = 0; k < 5; k++)
        begin
            drain_results();
            write_top_count(phase_setting[k]);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS)
            begin
                set_size = $urandom_range(1, 10);
                send_random_set(set_size, $urandom_range(0, 3) == 0);
                phase_count += set_size;
            end
        end

        drain_results();
        $display("Sent %0d records in %0d sets under %0d top_count settings.",
                 records_sent, tracker.sets_closed, settings_used);
        $display("Checked %0d ranked results, with a full store, clipped counts and ties.",
                 tracker.checked);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("top_k_record_ranker_core verification clean");
        else
            $display("top_k_record_ranker_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tkr_pkg.sv
design/tkr_cfg_regs.sv
design/top_k_record_ranker_core.sv
tb/top_k_record_ranker_core_tb.sv
